// ----- rtl/fast_packet_reassembler_top_defines.svh -----
// Assertion macros, left empty in synthesis builds.
`ifndef FAST_PACKET_REASSEMBLER_TOP_DEFINES_SVH
`define FAST_PACKET_REASSEMBLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FPR_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FPR_NEVER(lbl, cond, msg) `FPR_CHECK(lbl, !(cond), msg)
`else
`define FPR_CHECK(lbl, prop, msg)
`define FPR_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/fpr_pkg.sv -----
package fpr_pkg;

	localparam int NFAST = 13;
	localparam logic [17:0] FAST_PGNS [NFAST] = '{
		18'd126464, 18'd126996, 18'd65240, 18'd126208, 18'd129038, 18'd129039, 18'd129041,
		18'd129793, 18'd129794, 18'd129798, 18'd129802, 18'd129809, 18'd129810
	};

	localparam logic [1:0] ST_SINGLE   = 2'd0;
	localparam logic [1:0] ST_PENDING  = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;
	localparam logic [1:0] ST_DROPPED  = 2'd3;

	localparam logic [4:0] LAST_WORD = 5'd31;

	typedef enum logic [2:0] {
		OUT_SINGLE,
		OUT_SHORT,
		OUT_DROP,
		OUT_PEND,
		OUT_WORD
	} out_sel_t;

	typedef struct packed {
		logic     capture;
		logic     lookup;
		logic     open;
		logic     clr_we;
		logic     wr_lo;
		logic     wr_hi;
		logic     upd;
		logic     out_load;
		out_sel_t out_sel;
		logic [4:0] word;
	} cmd_t;

	typedef struct packed {
		logic fast;
		logic hit;
		logic free_any;
		logic short_len;
		logic done;
		logic last_word;
		logic out_free;
	} stat_t;

	function automatic logic is_fast(input logic [17:0] pgn);
		logic r;
		r = 1'b0;
		for (int k = 0; k < NFAST; k++) begin
			if (FAST_PGNS[k] == pgn) r = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/fpr_datapath.sv -----
module fpr_datapath #(
	parameter int SESSIONS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [119:0]  s_tdata,
	input  fpr_pkg::cmd_t cmd,
	output fpr_pkg::stat_t stat,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,
	output logic [1:0]    m_tuser,
	output logic          m_tlast
);
`include "fast_packet_reassembler_top_defines.svh"

	localparam int SW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int DEPTH = SESSIONS * 32;
	localparam int AW    = $clog2(DEPTH);

	logic [28:0] id_q;
	logic [17:0] pgn_q;
	logic [3:0]  flen_q;
	logic [63:0] fdata_q;

	logic        valid_q [SESSIONS];
	logic [28:0] sid_q   [SESSIONS];
	logic [2:0]  sseq_q  [SESSIONS];
	logic [17:0] spgn_q  [SESSIONS];
	logic [7:0]  slen_q  [SESSIONS];
	logic [7:0]  sleft_q [SESSIONS];

	logic [SW-1:0] sel_q;
	logic [63:0]   mem [DEPTH];
	logic [63:0]   rdata_q;

	logic [SESSIONS-1:0] match;
	logic [SW-1:0] hit_idx, free_idx;
	logic          hit, free_any;
	logic [7:0]    byte1, slen, sleft, cnt7, bo;
	logic [4:0]    wb;
	logic [2:0]    sh;
	logic [127:0]  win;
	logic [15:0]   be;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata;
	logic [7:0]    wbe;
	logic          we;

	assign byte1 = fdata_q[15:8];
	assign slen  = slen_q[sel_q];
	assign sleft = sleft_q[sel_q];
	assign cnt7  = (sleft >= 8'd7) ? 8'd7 : sleft;

	always_comb begin
		hit = 1'b0;
		free_any = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int s = SESSIONS - 1; s >= 0; s--) begin
			match[s] = valid_q[s] && sid_q[s] == id_q && sseq_q[s] == fdata_q[7:5];
			if (match[s]) begin
				hit = 1'b1;
				hit_idx = SW'(s);
			end
			if (!valid_q[s]) begin
				free_any = 1'b1;
				free_idx = SW'(s);
			end
		end
	end

	// byte i of a follow-on frame lands at offset 7q+i-2; biased by 8 to stay positive
	assign bo  = {fdata_q[4:0], 3'b000} - {3'b000, fdata_q[4:0]} + 8'd6;
	assign wb  = bo[7:3];
	assign sh  = bo[2:0];
	assign win = {64'd0, fdata_q} << {sh, 3'b000};

	always_comb begin
		logic [4:0] idx;
		logic [8:0] biased;
		for (int p = 0; p < 16; p++) begin
			idx = 5'(p) - {2'b00, sh};
			biased = {1'b0, wb, 3'b000} + 9'(p);
			be[p] = (5'(p) >= {2'b00, sh}) && idx >= 5'd1 && {3'b000, idx} <= cnt7
				&& biased >= 9'd8 && biased < ({1'b0, slen} + 9'd8);
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = AW'({sel_q, cmd.word});
		wdata = '0;
		wbe = '0;
		if (cmd.clr_we) begin
			we = 1'b1;
			wbe = '1;
			if (cmd.word == 5'd0) wdata = {16'd0, fdata_q[63:16]};
		end else if (cmd.wr_lo) begin
			we = 1'b1;
			waddr = AW'({sel_q, wb - 5'd1});
			wdata = win[63:0];
			wbe = be[7:0];
		end else if (cmd.wr_hi) begin
			we = 1'b1;
			waddr = AW'({sel_q, wb});
			wdata = win[127:64];
			wbe = be[15:8];
		end
	end

	assign raddr = AW'({sel_q, cmd.word});

	always_ff @(posedge clk) begin
		if (we) begin
			for (int k = 0; k < 8; k++) begin
				if (wbe[k]) mem[waddr][8*k +: 8] <= wdata[8*k +: 8];
			end
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q    <= s_tdata[28:0];
			pgn_q   <= s_tdata[46:29];
			flen_q  <= s_tdata[50:47];
			fdata_q <= s_tdata[114:51];
		end
		if (cmd.lookup) sel_q <= hit ? hit_idx : free_idx;
		if (cmd.open) begin
			sid_q[free_idx]   <= id_q;
			sseq_q[free_idx]  <= fdata_q[7:5];
			spgn_q[free_idx]  <= pgn_q;
			slen_q[free_idx]  <= byte1;
			sleft_q[free_idx] <= byte1 - 8'd6;
		end
		if (cmd.upd) sleft_q[sel_q] <= (sleft <= 8'd7) ? 8'd0 : sleft - 8'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SESSIONS; s++) valid_q[s] <= 1'b0;
		end else begin
			if (cmd.open) valid_q[free_idx] <= 1'b1;
			if (cmd.upd && sleft <= 8'd7) valid_q[sel_q] <= 1'b0;
		end
	end

	assign stat.fast      = fpr_pkg::is_fast(pgn_q);
	assign stat.hit       = hit;
	assign stat.free_any  = free_any;
	assign stat.short_len = byte1 <= 8'd6;
	assign stat.done      = sleft <= 8'd7;
	assign stat.last_word = cmd.word == 5'((slen - 8'd1) >> 3);
	assign stat.out_free  = !m_tvalid || m_tready;

	// output register
	logic        ov_q;
	logic [1:0]  ost_q;
	logic [28:0] oid_q;
	logic [17:0] opgn_q;
	logic [7:0]  olen_q, ooff_q;
	logic [63:0] oword_q;
	logic        olast_q;

	logic [1:0]  n_st;
	logic [17:0] n_pgn;
	logic [7:0]  n_len, n_off, flen8;
	logic [63:0] n_word;
	logic        n_last;

	assign flen8 = (flen_q > 4'd8) ? 8'd8 : {4'd0, flen_q};

	always_comb begin
		n_st = fpr_pkg::ST_SINGLE;
		n_pgn = pgn_q;
		n_len = flen8;
		n_off = '0;
		n_word = '0;
		n_last = 1'b1;
		case (cmd.out_sel)
			fpr_pkg::OUT_SINGLE: begin
				for (int b = 0; b < 8; b++)
					if (8'(b) < flen8) n_word[8*b +: 8] = fdata_q[8*b +: 8];
			end
			fpr_pkg::OUT_SHORT: begin
				n_st = fpr_pkg::ST_COMPLETE;
				n_len = byte1;
				for (int b = 0; b < 6; b++)
					if (8'(b) < byte1) n_word[8*b +: 8] = fdata_q[8*b+16 +: 8];
			end
			fpr_pkg::OUT_DROP: begin
				n_st = fpr_pkg::ST_DROPPED;
				n_len = byte1;
			end
			fpr_pkg::OUT_PEND: begin
				n_st = fpr_pkg::ST_PENDING;
				n_pgn = spgn_q[sel_q];
				n_len = slen;
			end
			fpr_pkg::OUT_WORD: begin
				n_st = fpr_pkg::ST_COMPLETE;
				n_pgn = spgn_q[sel_q];
				n_len = slen;
				n_off = {cmd.word, 3'b000};
				n_last = stat.last_word;
				for (int b = 0; b < 8; b++)
					if ({cmd.word, 3'(b)} < slen) n_word[8*b +: 8] = rdata_q[8*b +: 8];
			end
			default: n_st = fpr_pkg::ST_SINGLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ost_q   <= n_st;
			oid_q   <= id_q;
			opgn_q  <= n_pgn;
			olen_q  <= n_len;
			ooff_q  <= n_off;
			oword_q <= n_word;
			olast_q <= n_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = ost_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {1'b0, oword_q, ooff_q, olen_q, opgn_q, oid_q};

	`FPR_CHECK(a_load_free, cmd.out_load |-> stat.out_free, "result loaded over an untaken one")
	`FPR_CHECK(a_key_unique, $onehot0(match), "two sessions hold the same key")
	`FPR_CHECK(a_open_free, cmd.open |-> (!hit && free_any), "session opened without a free slot")

endmodule

// ----- rtl/fpr_ctrl.sv -----
module fpr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  fpr_pkg::stat_t stat,
	output fpr_pkg::cmd_t  cmd
);
`include "fast_packet_reassembler_top_defines.svh"

	typedef enum logic [2:0] {
		IDLE, LOOKUP, CLEAR, WR_LO, WR_HI, RD, RDW, EMIT
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;
	fpr_pkg::out_sel_t sel_q;

	assign s_tready = state_q == IDLE;

	always_comb begin
		cmd = '0;
		cmd.word = cnt_q;
		cmd.out_sel = sel_q;
		case (state_q)
			IDLE:   cmd.capture = s_tvalid;
			LOOKUP: begin
				cmd.lookup = 1'b1;
				cmd.open = stat.fast && !stat.hit && !stat.short_len && stat.free_any;
			end
			CLEAR:  cmd.clr_we = 1'b1;
			WR_LO:  cmd.wr_lo = 1'b1;
			WR_HI: begin
				cmd.wr_hi = 1'b1;
				cmd.upd = 1'b1;
			end
			RDW: begin
				cmd.out_sel = fpr_pkg::OUT_WORD;
				cmd.out_load = stat.out_free;
			end
			EMIT:   cmd.out_load = stat.out_free;
			default: cmd.capture = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			sel_q <= fpr_pkg::OUT_SINGLE;
		end else begin
			case (state_q)
				IDLE: if (s_tvalid) state_q <= LOOKUP;
				LOOKUP: begin
					cnt_q <= '0;
					if (!stat.fast) begin
						sel_q <= fpr_pkg::OUT_SINGLE;
						state_q <= EMIT;
					end else if (stat.hit) begin
						state_q <= WR_LO;
					end else if (stat.short_len) begin
						sel_q <= fpr_pkg::OUT_SHORT;
						state_q <= EMIT;
					end else if (!stat.free_any) begin
						sel_q <= fpr_pkg::OUT_DROP;
						state_q <= EMIT;
					end else begin
						state_q <= CLEAR;
					end
				end
				CLEAR: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == fpr_pkg::LAST_WORD) begin
						sel_q <= fpr_pkg::OUT_PEND;
						state_q <= EMIT;
					end
				end
				WR_LO: state_q <= WR_HI;
				WR_HI: begin
					cnt_q <= '0;
					if (stat.done) begin
						state_q <= RD;
					end else begin
						sel_q <= fpr_pkg::OUT_PEND;
						state_q <= EMIT;
					end
				end
				RD: state_q <= RDW;
				RDW: if (stat.out_free) begin
					if (stat.last_word) begin
						state_q <= IDLE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
						state_q <= RD;
					end
				end
				EMIT: if (stat.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	`FPR_CHECK(a_clear_ends, (state_q == CLEAR && cnt_q == fpr_pkg::LAST_WORD) |=> state_q == EMIT,
		"clear sweep overran")
	`FPR_CHECK(a_hi_after_lo, state_q == WR_LO |=> state_q == WR_HI, "frame write split")
	`FPR_NEVER(a_one_write, cmd.clr_we && (cmd.wr_lo || cmd.wr_hi), "two buffer writes at once")

endmodule

// ----- rtl/fast_packet_reassembler_top.sv -----
// Fast-packet reassembler: takes one received CAN frame per input transaction and
// gives one or more result transactions, m_tlast marking the last for that frame.
// Frames are handled one at a time; the output register lets the next frame be
// taken while a result waits. A single-frame message, short fast packet or drop
// is looked up and emitted; a follow-on frame is written in two halves and, when
// it completes the message, read out one 8-byte word at a time (one read of the
// assembly memory per word). A frame that opens a session first clears the
// session's 32 words of assembly memory, one per cycle through its one write port.
// A result held by m_tready low adds its wait to the handling of a frame.
// No clearing pass follows reset.
module fast_packet_reassembler_top #(
	parameter int SESSIONS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // can_id, pgn, frame_length, frame_data
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // msg_can_id, msg_pgn, msg_length, byte_offset, data_word
	output logic [1:0]   m_tuser,  // status
	output logic         m_tlast
);

	fpr_pkg::cmd_t  cmd;
	fpr_pkg::stat_t stat;

	fpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fpr_datapath #(.SESSIONS(SESSIONS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
